/* src/ahfr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16-CCITT byte update for the AIS HDLC receiver.
package ahfr_pkg;

    localparam int AMP_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 8;
    localparam int ID_W      = 6;
    localparam int CRC_W     = 16;
    localparam int CMP_W     = 10;   // room for header + length + 2 and a 9-bit count

    localparam logic [CRC_W-1:0] CRC_INIT   = 16'hFFFF;
    localparam logic [2:0]       ONES_LIMIT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_WEAK_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MESSAGE_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LENGTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LENGTH    = 2'd3;

    typedef struct packed {
        logic             frame_start;
        logic             fm_positive;
        logic [AMP_W-1:0] amplitude;
        logic             last_sample;
    } sym_t;

    typedef struct packed {
        logic [AMP_W-1:0] weak_threshold;
        logic [ID_W-1:0]  long_message_id;
        logic [LEN_W-1:0] long_length;
        logic [LEN_W-1:0] short_length;
    } cfg_t;

    typedef struct packed {
        logic            valid;
        logic            is_frame_end;
        logic [7:0]      byte_value;
        logic [7:0]      byte_index;
        logic            crc_ok;
        logic [ID_W-1:0] message_id;
    } res_t;

    // Reflected CCITT update, one byte.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [7:0] data);
        logic [7:0] d;
        d = data ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
    endfunction

endpackage

/* src/ahfr_frame_core.sv */
`timescale 1ns / 1ps
// Frame state and per-symbol NRZI decode, destuffing, byte packing and CRC.
module ahfr_frame_core #(
    parameter int MAX_BYTES    = 256,
    parameter int HEADER_BYTES = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  ahfr_pkg::sym_t sym,
    input  ahfr_pkg::cfg_t cfg,
    output ahfr_pkg::res_t res
);
    import ahfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    logic             in_frame_reg,   in_frame_next;
    logic             prev_valid_reg, prev_valid_next;
    logic             prev_bit_reg,   prev_bit_next;
    logic [2:0]       ones_reg,       ones_next;
    logic [2:0]       pos_reg,        pos_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [7:0]       shift_reg,      shift_next;
    logic [CRC_W-1:0] crc_reg,        crc_next;
    logic [CRC_W-1:0] final_reg,      final_next;
    logic [CRC_W-1:0] rx_reg,         rx_next;
    logic [LEN_W-1:0] plen_reg,       plen_next;
    logic [ID_W-1:0]  mid_reg,        mid_next;

    always_comb begin
        logic             live;
        logic             weak_end;
        logic             line_bit;
        logic             dbit;
        logic             byte_done;
        logic [7:0]       done_value;
        logic [CMP_W-1:0] idx_ext;
        logic [CMP_W-1:0] rel;
        logic [CMP_W-1:0] plen_ext;
        logic [CMP_W-1:0] cnt_ext;
        logic             ok;
        logic             frame_end;

        // Current view: frame_start restarts the decoder before this symbol.
        if (sym.frame_start) begin
            prev_valid_next = 1'b0;
            prev_bit_next   = 1'b0;
            ones_next       = '0;
            pos_next        = '0;
            count_next      = '0;
            shift_next      = '0;
            crc_next        = CRC_INIT;
            final_next      = '0;
            rx_next         = '0;
            plen_next       = '0;
            mid_next        = '0;
        end else begin
            prev_valid_next = prev_valid_reg;
            prev_bit_next   = prev_bit_reg;
            ones_next       = ones_reg;
            pos_next        = pos_reg;
            count_next      = count_reg;
            shift_next      = shift_reg;
            crc_next        = crc_reg;
            final_next      = final_reg;
            rx_next         = rx_reg;
            plen_next       = plen_reg;
            mid_next        = mid_reg;
        end
        live          = sym.frame_start | in_frame_reg;
        in_frame_next = live;
        weak_end      = (sym.amplitude < cfg.weak_threshold) ||
                        (count_next >= CNT_W'(MAX_BYTES));
        line_bit      = ~sym.fm_positive;
        dbit          = prev_valid_next && (line_bit == prev_bit_next);
        byte_done     = 1'b0;
        done_value    = '0;
        idx_ext       = CMP_W'(count_next);
        rel           = '0;
        plen_ext      = '0;

        if (live && !weak_end) begin
            prev_valid_next = 1'b1;
            prev_bit_next   = line_bit;
            if (ones_next >= ONES_LIMIT && !dbit) begin
                ones_next = '0;                      // stuffed zero, dropped
            end else begin
                if (dbit) begin
                    ones_next = (ones_next >= ONES_LIMIT) ? 3'd1 : ones_next + 3'd1;
                end else begin
                    ones_next = '0;
                end
                done_value = shift_next | (8'(dbit) << pos_next);
                shift_next = done_value;
                pos_next   = pos_next + 3'd1;
                if (pos_next == 3'd0) begin
                    byte_done = 1'b1;
                    if (count_next == CNT_W'(HEADER_BYTES)) begin
                        mid_next  = done_value[7:2];
                        plen_next = (mid_next == cfg.long_message_id) ? cfg.long_length
                                                                       : cfg.short_length;
                    end
                    plen_ext = CMP_W'(plen_next);
                    if (idx_ext >= CMP_W'(HEADER_BYTES)) begin
                        rel = idx_ext - CMP_W'(HEADER_BYTES);
                        if (rel < plen_ext) begin
                            crc_next   = crc16_byte(crc_next, done_value);
                            final_next = ~crc_next;
                        end else if (rel == plen_ext) begin
                            rx_next[7:0] = done_value;
                        end else if (rel == plen_ext + CMP_W'(1)) begin
                            rx_next[15:8] = done_value;
                        end
                    end
                    count_next = count_next + CNT_W'(1);
                    shift_next = '0;
                end
            end
        end

        cnt_ext   = CMP_W'(count_next);
        ok        = (cnt_ext > CMP_W'(HEADER_BYTES)) &&
                    (cnt_ext >= CMP_W'(HEADER_BYTES) + CMP_W'(plen_next) + CMP_W'(2)) &&
                    (final_next == rx_next);
        frame_end = live && (weak_end || sym.last_sample);
        if (frame_end) begin
            in_frame_next = 1'b0;
        end

        res.valid        = frame_end || (live && byte_done);
        res.is_frame_end = frame_end;
        res.byte_value   = frame_end ? 8'h00 : done_value;
        res.byte_index   = frame_end ? ((cnt_ext > CMP_W'(255)) ? 8'hFF : cnt_ext[7:0])
                                     : idx_ext[7:0];
        res.crc_ok       = frame_end && ok;
        res.message_id   = mid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_bit_reg   <= 1'b0;
            ones_reg       <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            shift_reg      <= '0;
            crc_reg        <= CRC_INIT;
            final_reg      <= '0;
            rx_reg         <= '0;
            plen_reg       <= '0;
            mid_reg        <= '0;
        end else if (step && (sym.frame_start || in_frame_reg)) begin
            in_frame_reg   <= in_frame_next;
            prev_valid_reg <= prev_valid_next;
            prev_bit_reg   <= prev_bit_next;
            ones_reg       <= ones_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            shift_reg      <= shift_next;
            crc_reg        <= crc_next;
            final_reg      <= final_next;
            rx_reg         <= rx_next;
            plen_reg       <= plen_next;
            mid_reg        <= mid_next;
        end
    end

    // run of ones never passes the stuffing limit
    a_ones_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ones_reg <= ONES_LIMIT)
        else $error("ones run above limit");

    // buffer count never exceeds capacity
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BYTES))
        else $error("byte count above buffer size");

endmodule

/* src/ais_hdlc_frame_receiver.sv */
`timescale 1ns / 1ps
// Top level of the AIS HDLC frame receiver: ports, config registers, in/out registers.
//
// Input stream: one demodulated symbol per word. s_tuser = frame_start (restarts
// the decoder), s_tlast = last sample of the buffer, s_tdata = fm_positive and
// amplitude. Output stream: one word per completed byte (m_tlast low) or one
// end-of-frame report (m_tlast high) with byte count, CRC match and message id.
// Symbols that close no byte and end no frame produce no output word.
// Pipeline: two register stages, input and result; a word accepted into the input
// register is decoded when it advances, and its result goes to the result register.
// Throughput: one symbol per cycle unless stalled; all per-symbol work (NRZI, destuff,
// byte pack, one CRC byte step) sits between the input and result registers.
// Stall: when m_tready is low and a result is held, the symbol in the input
// register waits and s_tready drops only once that register is also full.
// Reset (aresetn low, synchronous): both stages empty, frame closed, config
// registers back to weak_threshold 4, long id 5, long length 53, short length 21.
// Config writes (cfg_wen/cfg_addr/cfg_wdata) take effect at once; write only
// while the stream is idle.
module ais_hdlc_frame_receiver #(
    parameter int MAX_BYTES    = 256,
    parameter int HEADER_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_addr,
    input  logic [19:0] cfg_wdata,
    // symbol stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] fm_positive, [20:1] amplitude, [23:21] zero
    input  logic [0:0]  s_tuser,   // [0] frame_start
    input  logic        s_tlast,   // last_sample
    // byte / report stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] byte_value, [15:8] byte_index, [16] crc_ok,
                                   // [22:17] message_id, [23] zero
    output logic        m_tlast    // is_frame_end
);
    import ahfr_pkg::*;

    cfg_t cfg_reg;
    sym_t in_item_reg;
    logic in_valid_reg, in_valid_next;
    res_t out_reg;
    logic out_valid_reg, out_valid_next;
    res_t core_res;
    logic advance;
    logic s_accept;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.weak_threshold  <= 20'd4;
            cfg_reg.long_message_id <= 6'd5;
            cfg_reg.long_length     <= 8'd53;
            cfg_reg.short_length    <= 8'd21;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_WEAK_THRESHOLD:  cfg_reg.weak_threshold  <= cfg_wdata;
                REG_LONG_MESSAGE_ID: cfg_reg.long_message_id <= cfg_wdata[ID_W-1:0];
                REG_LONG_LENGTH:     cfg_reg.long_length     <= cfg_wdata[LEN_W-1:0];
                REG_SHORT_LENGTH:    cfg_reg.short_length    <= cfg_wdata[LEN_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // decode the held symbol when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && core_res.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.frame_start <= s_tuser[0];
            in_item_reg.fm_positive <= s_tdata[0];
            in_item_reg.amplitude   <= s_tdata[AMP_W:1];
            in_item_reg.last_sample <= s_tlast;
        end
        if (advance && core_res.valid) begin
            out_reg <= core_res;
        end
    end

    ahfr_frame_core #(
        .MAX_BYTES    (MAX_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .sym     (in_item_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.is_frame_end;
    assign m_tdata  = {1'b0, out_reg.message_id, out_reg.crc_ok,
                       out_reg.byte_index, out_reg.byte_value};

    // an end report never carries a byte value
    a_end_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
        else $error("end report with nonzero byte");

    // a byte word never claims a CRC match
    a_byte_no_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tdata[16])
        else $error("crc_ok set on byte word");

    // a new output word only appears when a held symbol was decoded
    a_out_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("output without decoded symbol");

endmodule
